FILE: design/priority_message_queue_assert.svh
// Assertion macros used by the checker file of the message queue.
`ifndef PRIORITY_MESSAGE_QUEUE_ASSERT_SVH
`define PRIORITY_MESSAGE_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge and idle in reset.
`define PMQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("priority message queue check failed");

// Next-cycle implication, sampled on the rising clock edge and idle in reset.
`define PMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("priority message queue check failed");

`endif

FILE: design/pmq_pkg.sv
package pmq_pkg;

    // Built size of the queue and the default size limit.
    localparam int QUEUE_DEPTH      = 16;
    localparam int DEFAULT_MSG_SIZE = 1024;

    // Widths; AW, AW1 and CNT_W are derived from the depth.
    localparam int AW       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int AW1      = AW + 1;
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int FILL_W   = 5;
    localparam int PRIO_W   = 16;
    localparam int SIZE_W   = 16;
    localparam int WORD_W   = 32;
    localparam int MLIM_W   = 5;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 1;

    // Operation codes.
    localparam logic MODE_SEND = 1'b0;
    localparam logic MODE_RECV = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_DONE   = 2'd0;
    localparam logic [1:0] STATUS_REJECT = 2'd1;
    localparam logic [1:0] STATUS_EMPTY  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MSG_LIMIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_LIMIT = 1'd1;

    // One stored message.
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [SIZE_W-1:0] size;
        logic [WORD_W-1:0] word;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Effective limits after the zero-selects-default rules.
    typedef struct packed {
        logic [CNT_W-1:0]  msg_limit;
        logic [SIZE_W-1:0] size_limit;
    } limits_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INS_WALK,
        ST_INS_PUT,
        ST_POP
    } state_t;

endpackage

FILE: design/pmq_ram.sv
module pmq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/pmq_ctrl.sv
module pmq_ctrl
    import pmq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  limits_t            lim,
    input  logic               start,
    input  logic               mode,
    input  logic [PRIO_W-1:0]  priority_req,
    input  logic [SIZE_W-1:0]  msg_size,
    input  logic [WORD_W-1:0]  payload,
    output logic               busy,
    output logic               done,
    output logic [1:0]         status,
    output logic [PRIO_W-1:0]  out_priority,
    output logic [SIZE_W-1:0]  out_size,
    output logic [WORD_W-1:0]  out_payload,
    output logic [FILL_W-1:0]  fill,
    output logic               ram_wr_en,
    output logic [AW-1:0]      ram_wr_addr,
    output entry_t             ram_wr_data,
    output logic               ram_rd_en,
    output logic [AW-1:0]      ram_rd_addr,
    input  entry_t             ram_rd_data
);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    held_reg, held_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [AW-1:0]       idx_reg, idx_next;
    entry_t              new_reg, new_next;
    logic                done_reg, done_next;
    logic [1:0]          status_reg, status_next;
    entry_t              res_reg, res_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;

    logic                accept;
    logic                send_ok;
    logic                walk_shift;
    entry_t              in_entry;

    // Logical queue position to memory address on the circular buffer.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [AW-1:0] pos);
        logic [AW1-1:0] sum;
        sum = {1'b0, head} + {1'b0, pos};
        if (sum >= AW1'(QUEUE_DEPTH))
        begin
            sum = sum - AW1'(QUEUE_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign accept     = start && (state_reg == ST_IDLE);
    assign send_ok    = (held_reg < lim.msg_limit) && (msg_size <= lim.size_limit);
    assign walk_shift = ram_rd_data.prio < new_reg.prio;
    assign in_entry   = '{prio: priority_req, size: msg_size, word: payload};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && held_reg != '0)
                begin
                    if (mode == MODE_RECV)
                    begin
                        state_next = ST_POP;
                    end
                    else if (send_ok)
                    begin
                        state_next = ST_INS_WALK;
                    end
                end
            end
            ST_INS_WALK:
            begin
                if (!walk_shift)
                begin
                    state_next = ST_IDLE;
                end
                else if (idx_reg == '0)
                begin
                    state_next = ST_INS_PUT;
                end
            end
            ST_INS_PUT:
            begin
                state_next = ST_IDLE;
            end
            ST_POP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory accesses, queue bookkeeping and the result.
    always_comb
    begin
        held_next   = held_reg;
        head_next   = head_reg;
        idx_next    = idx_reg;
        new_next    = new_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        res_next    = res_reg;
        fill_next   = fill_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = phys(head_reg, idx_reg);
        ram_wr_data = new_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = head_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    new_next = in_entry;
                    res_next = '0;
                    if (mode == MODE_SEND)
                    begin
                        if (!send_ok)
                        begin
                            done_next   = 1'b1;
                            status_next = STATUS_REJECT;
                            fill_next   = FILL_W'(held_reg);
                        end
                        else if (held_reg == '0)
                        begin
                            // Empty queue: the new message becomes the head.
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = head_reg;
                            ram_wr_data = in_entry;
                            held_next   = held_reg + CNT_W'(1);
                            done_next   = 1'b1;
                            status_next = STATUS_DONE;
                            fill_next   = FILL_W'(held_reg + CNT_W'(1));
                        end
                        else
                        begin
                            // Start the walk at the tail.
                            idx_next    = AW'(held_reg - CNT_W'(1));
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = phys(head_reg, AW'(held_reg - CNT_W'(1)));
                        end
                    end
                    else
                    begin
                        if (held_reg == '0)
                        begin
                            done_next   = 1'b1;
                            status_next = STATUS_EMPTY;
                            fill_next   = '0;
                        end
                        else
                        begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = head_reg;
                        end
                    end
                end
            end
            ST_INS_WALK:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = phys(head_reg, idx_reg + AW'(1));
                if (walk_shift)
                begin
                    // Lower priority: move it one place back and look further ahead.
                    ram_wr_data = ram_rd_data;
                    if (idx_reg != '0)
                    begin
                        idx_next    = idx_reg - AW'(1);
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = phys(head_reg, idx_reg - AW'(1));
                    end
                end
                else
                begin
                    // Equal or higher priority ahead: insert right behind it.
                    ram_wr_data = new_reg;
                    held_next   = held_reg + CNT_W'(1);
                    done_next   = 1'b1;
                    status_next = STATUS_DONE;
                    fill_next   = FILL_W'(held_reg + CNT_W'(1));
                end
            end
            ST_INS_PUT:
            begin
                // Every held entry moved back: the new message is the head.
                ram_wr_en   = 1'b1;
                ram_wr_addr = head_reg;
                ram_wr_data = new_reg;
                held_next   = held_reg + CNT_W'(1);
                done_next   = 1'b1;
                status_next = STATUS_DONE;
                fill_next   = FILL_W'(held_reg + CNT_W'(1));
            end
            ST_POP:
            begin
                res_next    = ram_rd_data;
                head_next   = phys(head_reg, AW'(1));
                held_next   = held_reg - CNT_W'(1);
                done_next   = 1'b1;
                status_next = STATUS_DONE;
                fill_next   = FILL_W'(held_reg - CNT_W'(1));
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            held_reg  <= '0;
            head_reg  <= '0;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
            head_reg  <= head_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        new_reg    <= new_next;
        status_reg <= status_next;
        res_reg    <= res_next;
        fill_reg   <= fill_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign out_priority = res_reg.prio;
    assign out_size     = res_reg.size;
    assign out_payload  = res_reg.word;
    assign fill         = fill_reg;

endmodule

FILE: design/priority_message_queue.sv
// Steps to the done strobe: a refused send, an empty receive or a send into an empty queue
// finish straight from idle; a receive passes through ST_POP; a send into a non-empty
// queue walks from the tail in ST_INS_WALK past each lower-priority entry and ends there
// or in ST_INS_PUT. One transaction at a time, the next is taken at the edge that ends done.
// Reset (rst_n low, asynchronous) empties the queue and clears both limits to their defaults.
// Results are shown for one cycle with done high; the receiver cannot stall them.
module priority_message_queue
    import pmq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 start,
    output logic                 busy,
    input  logic                 mode,
    input  logic [PRIO_W-1:0]    priority_req,
    input  logic [SIZE_W-1:0]    msg_size,
    input  logic [WORD_W-1:0]    payload,
    output logic                 done,
    output logic [1:0]           status,
    output logic [PRIO_W-1:0]    out_priority,
    output logic [SIZE_W-1:0]    out_size,
    output logic [WORD_W-1:0]    out_payload,
    output logic [FILL_W-1:0]    fill
);

    logic [MLIM_W-1:0] msg_limit_reg, msg_limit_next;
    logic [SIZE_W-1:0] size_limit_reg, size_limit_next;
    limits_t           lim;
    logic              lim_full_depth;

    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    entry_t            ram_wr_data;
    logic              ram_rd_en;
    logic [AW-1:0]     ram_rd_addr;
    entry_t            ram_rd_data;

    // Configuration register writes.
    always_comb
    begin
        msg_limit_next  = msg_limit_reg;
        size_limit_next = size_limit_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_MSG_LIMIT:  msg_limit_next  = cfg_data[MLIM_W-1:0];
                REG_SIZE_LIMIT: size_limit_next = cfg_data[SIZE_W-1:0];
                default:        msg_limit_next  = msg_limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_limit_reg  <= '0;
            size_limit_reg <= '0;
        end
        else
        begin
            msg_limit_reg  <= msg_limit_next;
            size_limit_reg <= size_limit_next;
        end
    end

    // Effective limits: zero picks the default, the count limit saturates at the depth.
    assign lim_full_depth = (msg_limit_reg == '0) || (32'(msg_limit_reg) > QUEUE_DEPTH);
    assign lim.msg_limit  = lim_full_depth ? CNT_W'(QUEUE_DEPTH) : CNT_W'(msg_limit_reg);
    assign lim.size_limit = (size_limit_reg == '0) ? SIZE_W'(DEFAULT_MSG_SIZE)
                                                   : size_limit_reg;

    pmq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .lim          (lim),
        .start        (start),
        .mode         (mode),
        .priority_req (priority_req),
        .msg_size     (msg_size),
        .payload      (payload),
        .busy         (busy),
        .done         (done),
        .status       (status),
        .out_priority (out_priority),
        .out_size     (out_size),
        .out_payload  (out_payload),
        .fill         (fill),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data),
        .ram_rd_en    (ram_rd_en),
        .ram_rd_addr  (ram_rd_addr),
        .ram_rd_data  (ram_rd_data)
    );

    pmq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_entries (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

FILE: design/pmq_checker.sv
`include "priority_message_queue_assert.svh"

module pmq_checker
    import pmq_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic [1:0]         status,
    input logic [PRIO_W-1:0]  out_priority,
    input logic [SIZE_W-1:0]  out_size,
    input logic [WORD_W-1:0]  out_payload,
    input logic [FILL_W-1:0]  fill
);

    // An accepted transaction either finishes at once or keeps the block busy.
    `PMQ_ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, busy || done)

    // Only defined status codes are reported.
    `PMQ_ASSERT_NOW(a_status_code, clk, rst_n, done, status != 2'd3)

    // A refused send or an empty receive carries no message.
    `PMQ_ASSERT_NOW(a_no_message, clk, rst_n, done && status != STATUS_DONE,
        out_priority == '0 && out_size == '0 && out_payload == '0)

    // An empty receive reports an empty queue.
    `PMQ_ASSERT_NOW(a_empty_fill, clk, rst_n, done && status == STATUS_EMPTY, fill == '0)

    // The count never passes the built depth.
    `PMQ_ASSERT_NOW(a_fill_bound, clk, rst_n, done, 32'(fill) <= QUEUE_DEPTH)

endmodule

bind priority_message_queue pmq_checker u_pmq_checker (.*);
